// ===== rtl/core/b64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

  // Work queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  typedef enum logic [1:0] {
    JOB_ENC = 2'd0,
    JOB_DEC = 2'd1,
    JOB_ERR = 2'd2
  } job_kind_t;

  // One completed group (or error) ready to be unpacked into results
  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] bits;
    logic [1:0]  held;      // encode: bytes held in the group (1..3)
    logic [1:0]  last_idx;  // index of final result of this job
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [5:0] val;
  } dec_code_t;

  function automatic dec_code_t char_code(input logic [7:0] c);
    dec_code_t r;
    r = '{ok: 1'b1, pad: 1'b0, val: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.pad = 1'b1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_codec_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64 codec, standard alphabet with '=' padding.
// mode register (mode_we/mode_wdata): 0 encodes bytes to text, 1 decodes
// text to bytes. A write also clears any partial group; write only while
// the block is idle.
// Input request: data_byte/last_byte, taken when in_valid && !in_stall.
// Output request: out_byte/last_out/error, taken when out_valid && !out_stall.
// The front classifies each byte and builds groups; every completed group
// (or decode error) becomes one job in a 4-entry queue. The back unpacks
// the queue head into one result per cycle, while out_stall is low, through an output register.
// The first result of a group passes through its queue entry and then the
// output register (empty queue, free output).
// Throughput: one item per cycle in while the queue has room; the back emits
// one result per cycle while out_stall is low, so a long encode stream is
// bound by its four chars per three bytes; decode takes one char per cycle.
// in_stall rises only when the queue is full of unemitted jobs.
// A stalled output holds its result; the queue keeps filling until full.
// Reset (rst, synchronous) empties the queue, clears the group and
// selects encode mode.
module base64_codec_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mode_we,
  input  wire logic       mode_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_out,
  output logic            error
);

  b64_pkg::job_t      push_job;
  b64_pkg::job_t      head;
  b64_pkg::q_status_t status;
  logic               push;
  logic               pop;
  logic               accept;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  b64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .accept     (accept),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push       (push),
    .push_job   (push_job)
  );

  b64_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_out  (last_out),
    .error     (error)
  );

endmodule

`default_nettype wire

// ===== rtl/core/b64_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          mode_we,
  input  wire logic          mode_wdata,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output logic               push,
  output b64_pkg::job_t      push_job
);

  logic        mode;
  logic [1:0]  group_position, group_position_next;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  pad_count, pad_count_next;

  b64_pkg::dec_code_t code;
  logic [1:0]  pos;
  logic [23:0] merged;
  logic [1:0]  pad_new;
  logic        bad;

  assign code = b64_pkg::char_code(data_byte);

  always_comb begin
    group_position_next = group_position;
    group_bits_next     = group_bits;
    pad_count_next      = pad_count;
    push                = 1'b0;
    push_job            = '{kind: b64_pkg::JOB_ERR, bits: 24'd0, held: 2'd0,
                            last_idx: 2'd0, last: last_byte};
    pos                 = group_position;
    merged              = group_bits;
    pad_new             = pad_count;
    bad                 = 1'b0;

    if (mode == 1'b0) begin
      // encode: place byte in its slot of the 24-bit group
      pos = (group_position > 2'd2) ? 2'd0 : group_position;
      unique case (pos)
        2'd0:    merged = group_bits | {data_byte, 16'd0};
        2'd1:    merged = group_bits | {8'd0, data_byte, 8'd0};
        default: merged = group_bits | {16'd0, data_byte};
      endcase
      if (accept) begin
        if (pos < 2'd2 && !last_byte) begin
          group_position_next = pos + 2'd1;
          group_bits_next     = merged;
        end else begin
          push              = 1'b1;
          push_job.kind     = b64_pkg::JOB_ENC;
          push_job.bits     = merged;
          push_job.held     = pos + 2'd1;
          push_job.last_idx = 2'd3;
          group_position_next = 2'd0;
          group_bits_next     = 24'd0;
          pad_count_next      = 2'd0;
        end
      end
    end else begin
      pos = group_position;
      bad = !code.ok || (code.pad && pos < 2'd2) || (!code.pad && pad_count != 2'd0);
      if (code.pad) begin
        pad_new = pad_count + 2'd1;
      end else begin
        unique case (pos)
          2'd0:    merged = group_bits | {code.val, 18'd0};
          2'd1:    merged = group_bits | {6'd0, code.val, 12'd0};
          2'd2:    merged = group_bits | {12'd0, code.val, 6'd0};
          default: merged = group_bits | {18'd0, code.val};
        endcase
      end
      if (accept) begin
        if (bad || (pos < 2'd3 && last_byte)) begin
          // invalid char, misplaced pad, data after pad, or message ends mid-group
          push                = 1'b1;
          group_position_next = 2'd0;
          group_bits_next     = 24'd0;
          pad_count_next      = 2'd0;
        end else if (pos < 2'd3) begin
          group_position_next = pos + 2'd1;
          group_bits_next     = merged;
          pad_count_next      = pad_new;
        end else begin
          push              = 1'b1;
          push_job.kind     = b64_pkg::JOB_DEC;
          push_job.bits     = merged;
          push_job.last_idx = 2'd2 - pad_new;
          group_position_next = 2'd0;
          group_bits_next     = 24'd0;
          pad_count_next      = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b0;
      group_position <= 2'd0;
      group_bits     <= 24'd0;
      pad_count      <= 2'd0;
    end else if (mode_we) begin
      mode           <= mode_wdata;
      group_position <= 2'd0;
      group_bits     <= 24'd0;
      pad_count      <= 2'd0;
    end else begin
      group_position <= group_position_next;
      group_bits     <= group_bits_next;
      pad_count      <= pad_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64_pkg::job_t   push_job,
  input  wire logic            pop,
  output b64_pkg::job_t        head,
  output b64_pkg::q_status_t   status
);

  b64_pkg::job_t                 mem [b64_pkg::QDEPTH];
  logic [b64_pkg::QAW-1:0]       wr_ptr;
  logic [b64_pkg::QAW-1:0]       rd_ptr;
  logic [b64_pkg::QCW-1:0]       count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == b64_pkg::QCW'(b64_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + b64_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + b64_pkg::QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + b64_pkg::QCW'(1);
        2'b01:   count <= count - b64_pkg::QCW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < b64_pkg::QCW'(b64_pkg::QDEPTH)))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("job popped from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= b64_pkg::QCW'(b64_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/b64_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b64_pkg::job_t      head,
  input  wire b64_pkg::q_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_out,
  output logic                    error
);

  logic [1:0] k;
  logic       load;
  logic [7:0] byte_next;
  logic       err_next;
  logic [5:0] sextet;

  assign load = !status.empty && (!out_valid || !out_stall);
  assign pop  = load && (k == head.last_idx);

  always_comb begin
    unique case (k)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    byte_next = 8'd0;
    err_next  = 1'b0;
    unique case (head.kind)
      b64_pkg::JOB_ENC: begin
        byte_next = (k <= head.held) ? b64_pkg::enc_char(sextet) : b64_pkg::PAD_CHAR;
      end
      b64_pkg::JOB_DEC: begin
        unique case (k)
          2'd0:    byte_next = head.bits[23:16];
          2'd1:    byte_next = head.bits[15:8];
          default: byte_next = head.bits[7:0];
        endcase
      end
      default: begin
        err_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        k         <= pop ? 2'd0 : k + 2'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      error    <= err_next;
      last_out <= head.last && (k == head.last_idx);
    end
  end

  a_k_in_job: assert property (@(posedge clk) disable iff (rst)
    !status.empty |-> (k <= head.last_idx))
    else $error("result index past end of job");

endmodule

`default_nettype wire
